// File: hw/rtl/rau_pkg.sv
// Shared types, constants and codes for the rational arithmetic unit.
package rau_pkg;

	localparam int OperandWidth = 32;
	localparam int QueueDepth   = 2;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_req_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [62:0]        res_den;
		logic [1:0]         status;
	} out_req_t;

	// Classified request passed from front to back: signs and magnitudes.
	typedef struct packed {
		logic [1:0]  mode;
		logic        san;
		logic        sad;
		logic        sbn;
		logic        sbd;
		logic [31:0] man;
		logic [31:0] mad;
		logic [31:0] mbn;
		logic [31:0] mbd;
		logic [1:0]  status;
	} work_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL1,
		B_MUL2,
		B_MUL3,
		B_SUM,
		B_GCD,
		B_DIVN,
		B_DIVD,
		B_CHECK,
		B_OUT
	} back_state_t;

endpackage

// File: hw/rtl/rau_front.sv
// Front end: accept requests, split operands into sign and magnitude, flag errors.
module rau_front #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rau_pkg::in_req_t in_data,
	output logic             q_valid,
	input  logic             q_ready,
	output rau_pkg::work_t   q_data
);

	localparam int W = OPERAND_WIDTH;

	logic           full_q;
	rau_pkg::work_t data_q;
	rau_pkg::work_t cls;

	function automatic logic [32:0] split(input logic [31:0] raw);
		logic [W-1:0] v;
		logic [W-1:0] m;
		begin
			v = raw[W-1:0];
			m = v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
			split = {v[W-1], 32'(m)};
		end
	endfunction

	// Classify the incoming request
	always_comb begin
		logic [32:0] an, ad, bn, bd;
		an = split(in_data.a_num);
		ad = split(in_data.a_den);
		bn = split(in_data.b_num);
		bd = split(in_data.b_den);
		cls.mode = in_data.mode;
		cls.san = an[32]; cls.man = an[31:0];
		cls.sad = ad[32]; cls.mad = ad[31:0];
		cls.sbn = bn[32]; cls.mbn = bn[31:0];
		cls.sbd = bd[32]; cls.mbd = bd[31:0];
		if (ad[31:0] == '0 || bd[31:0] == '0)
			cls.status = rau_pkg::ST_ZERO_DEN;
		else if (in_data.mode == rau_pkg::MODE_DIV && bn[31:0] == '0)
			cls.status = rau_pkg::ST_DIV_ZERO;
		else
			cls.status = rau_pkg::ST_OK;
	end

	assign in_ready = !full_q || q_ready;
	assign q_valid  = full_q;
	assign q_data   = data_q;

	// Hold one classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			full_q <= 1'b1;
		end else if (q_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= cls;
		end
	end

endmodule

// File: hw/rtl/rau_queue.sv
// Small FIFO between front and back ends.
module rau_queue #(
	parameter int DEPTH = rau_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  rau_pkg::work_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output rau_pkg::work_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rau_pkg::work_t      mem_q [DEPTH];
	logic [AW-1:0]       wp_q, rp_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic                wr, rd;

	assign wr_ready = (cnt_q != DEPTH[$clog2(DEPTH+1)-1:0]);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		nxt = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= nxt(wp_q);
			if (rd) rp_q <= nxt(rp_q);
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// Count never exceeds depth
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH) else $error("queue count overflow");
	// A write into a full queue never occurs
	a_nowrfull: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == DEPTH && !rd) |=> cnt_q == DEPTH) else $error("queue lost entry");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 0 && !wr) |=> !rd_valid) else $error("queue phantom entry");

endmodule

// File: hw/rtl/rau_divider.sv
// Restoring radix-2 divider for 64-bit unsigned values, one bit per cycle.
module rau_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);

	logic [6:0]  cnt_q;
	logic [63:0] q_q, r_q, d_q;
	logic [64:0] trial;

	assign busy      = (cnt_q != '0);
	assign quotient  = q_q;
	assign remainder = r_q;
	assign trial = {r_q, q_q[63]} - {1'b0, d_q};

	// Shift one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

endmodule

// File: hw/rtl/rau_back.sv
// Back end: cross products, Euclid GCD on a shared divider, reduction, sign fixup.
module rau_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  rau_pkg::work_t    q_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rau_pkg::out_req_t out_data
);

	rau_pkg::back_state_t state_q, state_d;
	rau_pkg::work_t       w_q;
	logic [63:0]          p1_q, p2_q, p3_q, nmag_q, dmag_q, x_q, y_q;
	logic                 nneg_q, sq_q, ovf_q;
	logic                 div_start, div_busy, div_started_q;
	logic [63:0]          div_a, div_b, div_quo, div_rem;
	logic [63:0]          mul_res;
	logic [31:0]          mul_a, mul_b;
	logic [63:0]          sum_mag;
	logic                 sum_neg, dneg, res_neg;
	rau_pkg::out_req_t    res_q;

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .busy(div_busy),
		.quotient(div_quo), .remainder(div_rem)
	);

	// One 32x32 multiplier, shared by all three products
	always_comb begin
		if (state_q == rau_pkg::B_MUL1) begin
			unique case (w_q.mode)
				rau_pkg::MODE_MUL: begin mul_a = w_q.man; mul_b = w_q.mbn; end
				default:           begin mul_a = w_q.man; mul_b = w_q.mbd; end
			endcase
		end else if (state_q == rau_pkg::B_MUL3) begin
			mul_a = w_q.mad;
			mul_b = w_q.mbn;
		end else begin
			unique case (w_q.mode)
				rau_pkg::MODE_DIV: begin mul_a = w_q.mad; mul_b = w_q.mbn; end
				default:           begin mul_a = w_q.mad; mul_b = w_q.mbd; end
			endcase
		end
	end
	assign mul_res = {32'd0, mul_a} * {32'd0, mul_b};

	// Signed cross sum, or the single numerator product, and the denominator sign
	always_comb begin
		dneg = (w_q.mode == rau_pkg::MODE_DIV) ? (w_q.sad != w_q.sbn) :
			(w_q.sad != w_q.sbd);
		if (w_q.mode == rau_pkg::MODE_ADD || w_q.mode == rau_pkg::MODE_SUB) begin
			if ((w_q.san != w_q.sbd) == sq_q) begin
				sum_neg = sq_q;
				sum_mag = p1_q + p3_q;
			end else if (p1_q >= p3_q) begin
				sum_neg = (w_q.san != w_q.sbd);
				sum_mag = p1_q - p3_q;
			end else begin
				sum_neg = sq_q;
				sum_mag = p3_q - p1_q;
			end
		end else begin
			sum_mag = p1_q;
			sum_neg = (w_q.mode == rau_pkg::MODE_MUL) ?
				(w_q.san != w_q.sbn) : (w_q.san != w_q.sbd);
		end
	end

	assign res_neg = nneg_q && (nmag_q != 64'd0);

	// Divider operands per state
	always_comb begin
		div_a = x_q;
		div_b = y_q;
		if (state_q == rau_pkg::B_DIVN) begin
			div_a = nmag_q; div_b = x_q;
		end else if (state_q == rau_pkg::B_DIVD) begin
			div_a = dmag_q; div_b = x_q;
		end
	end
	assign div_start = !div_started_q && (state_q == rau_pkg::B_DIVN ||
		state_q == rau_pkg::B_DIVD || (state_q == rau_pkg::B_GCD && y_q != '0));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::B_IDLE:
				if (q_valid) state_d = (q_data.status == rau_pkg::ST_OK) ?
					rau_pkg::B_MUL1 : rau_pkg::B_OUT;
			rau_pkg::B_MUL1:  state_d = rau_pkg::B_MUL2;
			rau_pkg::B_MUL2:  state_d = rau_pkg::B_MUL3;
			rau_pkg::B_MUL3:  state_d = rau_pkg::B_SUM;
			rau_pkg::B_SUM:   state_d = rau_pkg::B_GCD;
			rau_pkg::B_GCD:
				if (y_q == '0 && !div_started_q) state_d = rau_pkg::B_DIVN;
			rau_pkg::B_DIVN:
				if (div_started_q && !div_busy) state_d = rau_pkg::B_DIVD;
			rau_pkg::B_DIVD:
				if (div_started_q && !div_busy) state_d = rau_pkg::B_CHECK;
			rau_pkg::B_CHECK: state_d = rau_pkg::B_OUT;
			rau_pkg::B_OUT:   if (!out_valid || out_ready) state_d = rau_pkg::B_IDLE;
			default:          state_d = rau_pkg::B_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_ready = (state_q == rau_pkg::B_IDLE);
	end

	logic out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rau_pkg::B_IDLE;
			div_started_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) div_started_q <= 1'b0;
			else if (div_start) div_started_q <= 1'b1;
			else if (state_q == rau_pkg::B_GCD && div_started_q && !div_busy)
				div_started_q <= 1'b0;
			if (state_q == rau_pkg::B_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::B_IDLE: begin
				w_q <= q_data;
			end
			rau_pkg::B_MUL1: begin
				p1_q <= mul_res;
				sq_q <= (w_q.sad != w_q.sbn) ^ (w_q.mode == rau_pkg::MODE_SUB);
			end
			rau_pkg::B_MUL2: begin
				p2_q <= mul_res;
			end
			rau_pkg::B_MUL3: begin
				p3_q <= mul_res;
			end
			rau_pkg::B_SUM: begin
				nmag_q <= sum_mag;
				nneg_q <= sum_neg ^ dneg;
				dmag_q <= p2_q;
			end
			default: ;
		endcase
		// Seed Euclid with numerator and denominator magnitudes
		if (state_q == rau_pkg::B_SUM) begin
			x_q <= sum_mag;
			y_q <= p2_q;
		end
		if (state_q == rau_pkg::B_GCD && div_started_q && !div_busy) begin
			x_q <= y_q;
			y_q <= div_rem;
		end
		if (state_q == rau_pkg::B_DIVN && div_started_q && !div_busy) nmag_q <= div_quo;
		if (state_q == rau_pkg::B_DIVD && div_started_q && !div_busy) dmag_q <= div_quo;
		// Flag a reduced fraction that does not fit the result fields
		if (state_q == rau_pkg::B_CHECK) begin
			ovf_q <= (!res_neg && nmag_q[63]) ||
				(res_neg && nmag_q > 64'h8000000000000000) || dmag_q[63];
		end
		if (state_q == rau_pkg::B_OUT && (!out_valid_q || out_ready)) begin
			if (w_q.status != rau_pkg::ST_OK) begin
				res_q <= '{res_num: '0, res_den: '0, status: w_q.status};
			end else if (ovf_q) begin
				res_q <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_OVERFLOW};
			end else begin
				res_q.res_num <= res_neg ? -nmag_q : nmag_q;
				res_q.res_den <= dmag_q[62:0];
				res_q.status  <= rau_pkg::ST_OK;
			end
		end
	end

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> state_q != rau_pkg::B_IDLE) else $error("request dropped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");

endmodule

// File: hw/rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit.
// Usage: present a request (mode, two signed fractions) on in_valid/in_ready;
// the reduced fraction and status come back on out_valid/out_ready.
// Each request gives exactly one result, in order.
// Timing: operand errors skip the back-end arithmetic; otherwise a request
// passes the front register, queue, products, sum, one division per Euclid
// step, the two reducing divisions and output, all dominated by the single
// 64-bit bit-serial divider in the back end.
// Throughput: one request in the back end at a time; a two-entry queue and
// a front register let new requests be taken while the back end works.
// Reset: arst_n clears all control state; no request or result is pending.
// Stall: while out_ready is low the result holds and the back end waits with
// its next result; front register and queue fill, then in_ready drops.
// Errors: zero denominator, division by a zero fraction and overflow are
// reported in status with zero numerator and denominator.
module rational_arith_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rau_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rau_pkg::out_req_t out_data
);

	logic           f_valid, f_ready, b_valid, b_ready;
	rau_pkg::work_t f_data, b_data;

	rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
	);

	rau_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_data), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(b_valid), .q_ready(b_ready),
		.q_data(b_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
